>>> rtl/assert_macros.svh
// Assertion helpers used by the parser unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check on every rising clock edge, skipped while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed")

// Check on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed")

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

>>> rtl/lppp_pkg.sv
package lppp_pkg;

    localparam int unsigned HDR_BYTES = 13;
    localparam int unsigned HDR_CNT_W = 4;

    // Configuration register indexes
    localparam logic [7:0] CFG_MAGIC_WORD       = 8'd0;
    localparam logic [7:0] CFG_EXPECTED_VERSION = 8'd1;

    // Field tags; the field index uses the same codes, FIELD_NONE meaning all done
    localparam logic [1:0] FIELD_SRC  = 2'd0;
    localparam logic [1:0] FIELD_DST  = 2'd1;
    localparam logic [1:0] FIELD_PAY  = 2'd2;
    localparam logic [1:0] FIELD_NONE = 2'd3;

    typedef enum logic [1:0] {
        LP_HIGH = 2'd0,
        LP_LOW  = 2'd1,
        LP_DATA = 2'd2
    } t_len_phase;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TOO_SHORT   = 3'd1,
        ST_BAD_MAGIC   = 3'd2,
        ST_BAD_VERSION = 3'd3,
        ST_TRUNCATED   = 3'd4,
        ST_TRAILING    = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]  field_tag;
        logic [7:0]  field_byte;
        logic        byte_valid;
        logic        packet_done;
        t_status     status;
        logic [7:0]  version_out;
        logic [7:0]  packet_type;
        logic [7:0]  flags_out;
        logic [63:0] counter_out;
    } t_result;

endpackage

>>> rtl/lppp_if.sv
interface lppp_pkt_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface lppp_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  field_tag;
    logic [7:0]  field_byte;
    logic        byte_valid;
    logic        packet_done;
    logic [2:0]  status;
    logic [7:0]  version_out;
    logic [7:0]  packet_type;
    logic [7:0]  flags_out;
    logic [63:0] counter_out;

    modport source (output valid, output field_tag, output field_byte, output byte_valid,
                    output packet_done, output status, output version_out,
                    output packet_type, output flags_out, output counter_out,
                    input ready);
    modport sink   (input valid, input field_tag, input field_byte, input byte_valid,
                    input packet_done, input status, input version_out,
                    input packet_type, input flags_out, input counter_out,
                    output ready);
endinterface

interface lppp_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/length_prefixed_packet_parser_unit.sv
// Channel   Dir  Payload                                         Handshake
// i_pkt     in   data_byte[7:0], last_byte                       valid/ready
// o_res     out  field_tag, field_byte, byte_valid, packet_done,  valid/ready
//                status, version_out, packet_type, flags_out,
//                counter_out[63:0]
// i_cfg     in   index[7:0], data[15:0]                          valid/ready
//
// One byte per cycle while i_pkt.ready is high; each result is registered before it leaves.
// The parse state advances on the request itself; the output register plus a skid
// entry let a new byte in every cycle, i_pkt.ready falls only when both are full.
// Reset (i_rst_n low, synchronous) clears parse state, the output queue, and sets
// magic_word to 0 and expected_version to 1. Configuration writes are always taken.
`include "assert_macros.svh"

module length_prefixed_packet_parser_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lppp_pkt_if.sink     i_pkt,
    lppp_cfg_if.sink     i_cfg,
    lppp_res_if.source   o_res
);
    import lppp_pkg::*;

    // configuration
    logic [15:0] r_magic_word;
    logic [7:0]  r_expected_version;

    // parse state
    logic [HDR_CNT_W-1:0] r_hdr_cnt,      u_hdr_cnt,      n_hdr_cnt;
    logic                 r_magic_bad,    u_magic_bad,    n_magic_bad;
    logic [7:0]           r_magic_high,   u_magic_high,   n_magic_high;
    logic [7:0]           r_version,      u_version,      n_version;
    logic [7:0]           r_type,         u_type,         n_type;
    logic [7:0]           r_flags,        u_flags,        n_flags;
    logic [63:0]          r_counter,      u_counter,      n_counter;
    logic [1:0]           r_field_idx,    u_field_idx,    n_field_idx;
    t_len_phase           r_phase,        u_phase,        n_phase;
    logic [7:0]           r_len_high,     u_len_high,     n_len_high;
    logic [15:0]          r_remaining,    u_remaining,    n_remaining;
    logic                 r_trailing,     u_trailing,     n_trailing;

    logic       emit;
    logic       pkt_fire;
    logic       res_fire;
    logic       new_res;
    logic [7:0] b;
    logic [15:0] len;
    logic [15:0] rem_dec;
    t_status    status;
    t_result    res;

    // output register and skid entry
    t_result r_main, r_skid;
    logic    r_main_v, r_skid_v;

    assign b        = i_pkt.data_byte;
    assign pkt_fire = i_pkt.valid && i_pkt.ready;
    assign res_fire = r_main_v && o_res.ready;
    assign len      = {r_len_high, b};
    assign rem_dec  = r_remaining - 16'd1;

    assign i_pkt.ready = !r_skid_v;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_word       <= 16'd0;
            r_expected_version <= 8'd1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_MAGIC_WORD:       r_magic_word       <= i_cfg.data;
                CFG_EXPECTED_VERSION: r_expected_version <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    // state update for the byte on the request
    always_comb begin
        u_hdr_cnt    = r_hdr_cnt;
        u_magic_bad  = r_magic_bad;
        u_magic_high = r_magic_high;
        u_version    = r_version;
        u_type       = r_type;
        u_flags      = r_flags;
        u_counter    = r_counter;
        u_field_idx  = r_field_idx;
        u_phase      = r_phase;
        u_len_high   = r_len_high;
        u_remaining  = r_remaining;
        u_trailing   = r_trailing;
        emit         = 1'b0;

        if (r_hdr_cnt != HDR_CNT_W'(HDR_BYTES)) begin
            case (r_hdr_cnt)
                4'd0:    u_magic_high = b;
                4'd1:    u_magic_bad  = ({r_magic_high, b} != r_magic_word);
                4'd2:    u_version    = b;
                4'd3:    u_type       = b;
                4'd4:    u_flags      = b;
                default: u_counter    = {r_counter[55:0], b};
            endcase
            u_hdr_cnt = r_hdr_cnt + 4'd1;
        end else if (r_field_idx == FIELD_NONE) begin
            u_trailing = 1'b1;
        end else begin
            unique case (r_phase)
                LP_HIGH: begin
                    u_len_high = b;
                    u_phase    = LP_LOW;
                end
                LP_LOW: begin
                    if (len == 16'd0) begin
                        u_field_idx = r_field_idx + 2'd1;
                        u_phase     = LP_HIGH;
                        u_remaining = 16'd0;
                    end else begin
                        u_remaining = len;
                        u_phase     = LP_DATA;
                    end
                end
                default: begin
                    emit        = 1'b1;
                    u_remaining = rem_dec;
                    if (rem_dec == 16'd0) begin
                        u_field_idx = r_field_idx + 2'd1;
                        u_phase     = LP_HIGH;
                    end
                end
            endcase
        end
    end

    // result built from the updated state
    always_comb begin
        if (u_hdr_cnt != HDR_CNT_W'(HDR_BYTES)) status = ST_TOO_SHORT;
        else if (u_magic_bad)                    status = ST_BAD_MAGIC;
        else if (u_version != r_expected_version) status = ST_BAD_VERSION;
        else if (u_field_idx != FIELD_NONE)      status = ST_TRUNCATED;
        else if (u_trailing)                     status = ST_TRAILING;
        else                                     status = ST_OK;

        res             = '0;
        res.field_tag   = emit ? r_field_idx : FIELD_NONE;
        res.field_byte  = emit ? b : 8'd0;
        res.byte_valid  = emit;
        res.status      = ST_OK;
        if (i_pkt.last_byte) begin
            res.packet_done = 1'b1;
            res.status      = status;
            if (status != ST_TOO_SHORT) begin
                res.version_out = u_version;
                res.packet_type = u_type;
                res.flags_out   = u_flags;
                res.counter_out = u_counter;
            end
        end
    end

    assign new_res = pkt_fire && (emit || i_pkt.last_byte);

    // take the updated state for each accepted byte; drop all parse state once the last byte is through
    always_comb begin
        n_hdr_cnt    = r_hdr_cnt;
        n_magic_bad  = r_magic_bad;
        n_magic_high = r_magic_high;
        n_version    = r_version;
        n_type       = r_type;
        n_flags      = r_flags;
        n_counter    = r_counter;
        n_field_idx  = r_field_idx;
        n_phase      = r_phase;
        n_len_high   = r_len_high;
        n_remaining  = r_remaining;
        n_trailing   = r_trailing;
        if (pkt_fire) begin
            if (i_pkt.last_byte) begin
                n_hdr_cnt    = '0;
                n_magic_bad  = 1'b0;
                n_magic_high = '0;
                n_version    = '0;
                n_type       = '0;
                n_flags      = '0;
                n_counter    = '0;
                n_field_idx  = FIELD_SRC;
                n_phase      = LP_HIGH;
                n_len_high   = '0;
                n_remaining  = '0;
                n_trailing   = 1'b0;
            end else begin
                n_hdr_cnt    = u_hdr_cnt;
                n_magic_bad  = u_magic_bad;
                n_magic_high = u_magic_high;
                n_version    = u_version;
                n_type       = u_type;
                n_flags      = u_flags;
                n_counter    = u_counter;
                n_field_idx  = u_field_idx;
                n_phase      = u_phase;
                n_len_high   = u_len_high;
                n_remaining  = u_remaining;
                n_trailing   = u_trailing;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_cnt    <= '0;
            r_magic_bad  <= 1'b0;
            r_magic_high <= '0;
            r_version    <= '0;
            r_type       <= '0;
            r_flags      <= '0;
            r_counter    <= '0;
            r_field_idx  <= FIELD_SRC;
            r_phase      <= LP_HIGH;
            r_len_high   <= '0;
            r_remaining  <= '0;
            r_trailing   <= 1'b0;
        end else begin
            r_hdr_cnt    <= n_hdr_cnt;
            r_magic_bad  <= n_magic_bad;
            r_magic_high <= n_magic_high;
            r_version    <= n_version;
            r_type       <= n_type;
            r_flags      <= n_flags;
            r_counter    <= n_counter;
            r_field_idx  <= n_field_idx;
            r_phase      <= n_phase;
            r_len_high   <= n_len_high;
            r_remaining  <= n_remaining;
            r_trailing   <= n_trailing;
        end
    end

    // output queue: skid is only filled while the main entry is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_main_v || res_fire) begin
            r_main_v <= r_skid_v || new_res;
            r_skid_v <= 1'b0;
        end else if (new_res) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_v || res_fire) begin
            r_main <= r_skid_v ? r_skid : res;
        end
        if (r_main_v && !res_fire && new_res) begin
            r_skid <= res;
        end
    end

    assign o_res.valid       = r_main_v;
    assign o_res.field_tag   = r_main.field_tag;
    assign o_res.field_byte  = r_main.field_byte;
    assign o_res.byte_valid  = r_main.byte_valid;
    assign o_res.packet_done = r_main.packet_done;
    assign o_res.status      = r_main.status;
    assign o_res.version_out = r_main.version_out;
    assign o_res.packet_type = r_main.packet_type;
    assign o_res.flags_out   = r_main.flags_out;
    assign o_res.counter_out = r_main.counter_out;

    `ASSERT_ALWAYS(a_skid_behind_main, i_clk, !r_skid_v || r_main_v || !i_rst_n);
    `ASSERT_CLK(a_hdr_cnt_range, i_clk, i_rst_n, r_hdr_cnt <= HDR_CNT_W'(HDR_BYTES));
    `ASSERT_CLK(a_done_clears, i_clk, i_rst_n,
        (pkt_fire && i_pkt.last_byte) |=> (r_hdr_cnt == '0 && r_field_idx == FIELD_SRC));
    `ASSERT_CLK(a_fields_need_hdr, i_clk, i_rst_n,
        (r_hdr_cnt != HDR_CNT_W'(HDR_BYTES)) |-> (r_field_idx == FIELD_SRC && r_phase == LP_HIGH));
    `ASSERT_CLK(a_status_only_done, i_clk, i_rst_n,
        (r_main_v && !r_main.packet_done) |-> (r_main.status == ST_OK && r_main.byte_valid));

endmodule
